[rtl/core/a2hks_pkg.sv]
// Shared types and constants for the ASCII to HID keystroke sequencer.
// No dependencies; every other file in rtl/core uses this package.
package a2hks_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int MAX_EVENTS  = 4;
   localparam int EV_IDX_W    = $clog2(MAX_EVENTS);
   localparam int EV_CNT_W    = $clog2(MAX_EVENTS + 1);
   localparam int CSR_IDX_W   = 2;

   // item modes
   localparam logic [1:0] MODE_LOAD      = 2'd0;
   localparam logic [1:0] MODE_TYPE      = 2'd1;
   localparam logic [1:0] MODE_TRANSLATE = 2'd2;
   localparam logic [1:0] MODE_FINISH    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ISO_REPL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ISO_KEY  = 2'd1;

   localparam logic [7:0] ISO_REPL_RESET = 8'd50;
   localparam logic [7:0] ISO_KEY_RESET  = 8'd100;

   localparam logic [7:0] HID_LSHIFT  = 8'hE1;
   localparam logic [7:0] HID_RALT    = 8'hE6;
   localparam logic [7:0] HID_MOD_BASE = 8'hE0;

   typedef struct packed {
      logic [7:0] hid_code;
      logic       pressed;
      logic       is_translation;
   } event_type;

   typedef struct packed {
      logic [EV_CNT_W-1:0]          count;
      event_type [MAX_EVENTS-1:0]   ev;
   } ev_list_type;

   typedef struct packed {
      logic shift;
      logic altgr;
   } held_type;

endpackage

[rtl/core/a2hks_if.sv]
// Channel interfaces for the keystroke sequencer: request, response, register write.
// Depends on a2hks_pkg for the register index width.
interface a2hks_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [6:0] table_index;
   logic [7:0] table_word;
   logic [7:0] char_code;
   modport source (output valid, mode, table_index, table_word, char_code, input ready);
   modport sink   (input valid, mode, table_index, table_word, char_code, output ready);
endinterface

interface a2hks_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] hid_code;
   logic       pressed;
   logic       is_translation;
   logic       last_of_run;
   modport source (output valid, hid_code, pressed, is_translation, last_of_run, input ready);
   modport sink   (input valid, hid_code, pressed, is_translation, last_of_run, output ready);
endinterface

interface a2hks_csr_if;
   logic                           valid;
   logic                           ready;
   logic [a2hks_pkg::CSR_IDX_W-1:0] index;
   logic [7:0]                     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/a2hks_table_ram.sv]
// Layout table memory: one write port, one registered read port.
// Depends on a2hks_pkg for depth and address width.
module a2hks_table_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [a2hks_pkg::TABLE_AW-1:0] wr_addr,
   input  logic [7:0]                    wr_data,
   input  logic                          rd_en,
   input  logic [a2hks_pkg::TABLE_AW-1:0] rd_addr,
   output logic [7:0]                    rd_data
);
   logic [7:0] mem [a2hks_pkg::TABLE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/core/a2hks_decode.sv]
// Entry decode and event list builder for one item, plus next modifier state.
// Depends on a2hks_pkg for types and HID constants.
module a2hks_decode (
   input  logic                   [1:0] mode,
   input  logic                   [7:0] char_code,
   input  logic                   [7:0] entry,
   input  logic                   [7:0] iso_repl,
   input  logic                   [7:0] iso_key,
   input  a2hks_pkg::held_type          held,
   output a2hks_pkg::ev_list_type       list,
   output a2hks_pkg::held_type          held_next
);
   logic       need_shift;
   logic       need_altgr;
   logic [7:0] masked;
   logic [7:0] code;
   logic [7:0] trans;

   // split the entry into modifier needs and key code
   always_comb begin
      need_shift = 1'b0;
      need_altgr = 1'b0;
      masked     = entry;
      if (entry[7:6] == 2'b11) begin
         need_altgr = 1'b1;
         masked     = {2'b00, entry[5:0]};
      end else if (entry[7]) begin
         need_shift = 1'b1;
         masked     = {1'b0, entry[6:0]};
      end
      code = (masked == iso_repl) ? iso_key : masked;
      if (char_code[7]) begin
         code       = 8'd0;
         need_shift = 1'b0;
         need_altgr = 1'b0;
      end
   end

   // translate: modifier block, high codes fold down, rest through the table
   always_comb begin
      if (char_code[7:3] == 5'b00010) begin
         trans = a2hks_pkg::HID_MOD_BASE | {5'd0, char_code[2:0]};
      end else if (char_code[7]) begin
         trans = {1'b0, char_code[6:0]};
      end else begin
         trans = code;
      end
   end

   always_comb begin
      logic [a2hks_pkg::EV_CNT_W-1:0] n;
      n         = '0;
      list.ev   = '0;
      held_next = held;
      case (mode)
         a2hks_pkg::MODE_TYPE: begin
            if (code != 8'd0) begin
               if (need_shift != held.shift) begin
                  list.ev[n[a2hks_pkg::EV_IDX_W-1:0]] = '{a2hks_pkg::HID_LSHIFT, need_shift, 1'b0};
                  n = n + 1'b1;
               end
               if (need_altgr != held.altgr) begin
                  list.ev[n[a2hks_pkg::EV_IDX_W-1:0]] = '{a2hks_pkg::HID_RALT, need_altgr, 1'b0};
                  n = n + 1'b1;
               end
               list.ev[n[a2hks_pkg::EV_IDX_W-1:0]] = '{code, 1'b1, 1'b0};
               n = n + 1'b1;
               list.ev[n[a2hks_pkg::EV_IDX_W-1:0]] = '{code, 1'b0, 1'b0};
               n = n + 1'b1;
               held_next.shift = need_shift;
               held_next.altgr = need_altgr;
            end
         end
         a2hks_pkg::MODE_TRANSLATE: begin
            list.ev[0] = '{trans, 1'b0, 1'b1};
            n = a2hks_pkg::EV_CNT_W'(1);
         end
         a2hks_pkg::MODE_FINISH: begin
            if (held.shift) begin
               list.ev[n[a2hks_pkg::EV_IDX_W-1:0]] = '{a2hks_pkg::HID_LSHIFT, 1'b0, 1'b0};
               n = n + 1'b1;
            end
            if (held.altgr) begin
               list.ev[n[a2hks_pkg::EV_IDX_W-1:0]] = '{a2hks_pkg::HID_RALT, 1'b0, 1'b0};
               n = n + 1'b1;
            end
            held_next = '0;
         end
         default: begin
            n = '0;
         end
      endcase
      list.count = n;
   end
endmodule

[rtl/core/a2hks_burst.sv]
// Response emitter: holds one item's event list, sends one word per cycle while ready.
// Depends on a2hks_pkg and the a2hks_rsp_if interface.
module a2hks_burst (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load_en,
   input  a2hks_pkg::ev_list_type    list,
   output logic                      free,
   a2hks_rsp_if.source               rsp
);
   logic                                busy_ff, busy_in;
   logic [a2hks_pkg::EV_IDX_W-1:0]      idx_ff, idx_in;
   logic [a2hks_pkg::EV_IDX_W-1:0]      last_ff, last_in;
   a2hks_pkg::event_type [a2hks_pkg::MAX_EVENTS-1:0] ev_ff, ev_in;
   logic                                take;
   logic                                done;
   logic [a2hks_pkg::EV_CNT_W-1:0]      last_wide;

   assign take      = busy_ff && rsp.ready;
   assign done      = take && (idx_ff == last_ff);
   assign free      = !busy_ff || done;
   assign last_wide = list.count - 1'b1;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      last_in = last_ff;
      ev_in   = ev_ff;
      if (load_en) begin
         // refill behind the last word of the previous burst
         busy_in = 1'b1;
         idx_in  = '0;
         last_in = last_wide[a2hks_pkg::EV_IDX_W-1:0];
         ev_in   = list.ev;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         last_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         last_ff <= last_in;
      end
      ev_ff <= ev_in;
   end

   assign rsp.valid          = busy_ff;
   assign rsp.hid_code       = ev_ff[idx_ff].hid_code;
   assign rsp.pressed        = ev_ff[idx_ff].pressed;
   assign rsp.is_translation = ev_ff[idx_ff].is_translation;
   assign rsp.last_of_run    = (idx_ff == last_ff);
endmodule

[rtl/core/ascii_to_hid_keystroke_sequencer.sv]
// Top level of the ASCII to HID keystroke sequencer.
// Depends on a2hks_pkg, a2hks_if, a2hks_table_ram, a2hks_decode and a2hks_burst.
//
//   channel  dir  words                                     handshake
//   req_if   in   mode, table_index, table_word, char_code  valid/ready
//   rsp_if   out  hid_code, pressed, is_translation, last   valid/ready
//   csr_if   in   index, data (0 iso replacement, 1 iso key) valid/ready, always ready
//
// An accepted word reads (and, for a load, also writes) the layout RAM in its accept cycle;
// the next cycle decodes it against the held modifiers, and 0 to 4 events go to the emitter
// once it is free. The response port sends one event per cycle while ready is high; a typed
// character that maps to a key yields 2 to 4 events, a skipped one none. The emitter holds
// a single event list, so the decode stage holds the next item while that list is sent.
// Synchronous reset clears pipeline and held modifiers and presets both registers; the table
// is undefined until loaded. A stalled response holds the decode stage and then the input.
module ascii_to_hid_keystroke_sequencer (
   input  logic         clock,
   input  logic         reset,
   a2hks_req_if.sink    req_if,
   a2hks_rsp_if.source  rsp_if,
   a2hks_csr_if.sink    csr_if
);
   logic                          accept;
   logic                          s1_valid_ff, s1_valid_in;
   logic [1:0]                    s1_mode_ff;
   logic [7:0]                    s1_char_ff;
   logic [7:0]                    entry;
   logic                          s1_go;
   logic                          burst_free;
   logic                          burst_load;
   logic [7:0]                    iso_repl_ff, iso_repl_in;
   logic [7:0]                    iso_key_ff, iso_key_in;
   a2hks_pkg::held_type           held_ff, held_next;
   a2hks_pkg::ev_list_type        list;

   // registers: always ready, unknown indexes drop
   assign csr_if.ready = 1'b1;

   always_comb begin
      iso_repl_in = iso_repl_ff;
      iso_key_in  = iso_key_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            a2hks_pkg::CSR_ISO_REPL: iso_repl_in = csr_if.data;
            a2hks_pkg::CSR_ISO_KEY:  iso_key_in  = csr_if.data;
            default: begin
               iso_repl_in = iso_repl_ff;
            end
         endcase
      end
   end

   // decode stage advances when it has nothing to send or the emitter takes its list
   assign s1_go        = s1_valid_ff && ((list.count == '0) || burst_free);
   assign req_if.ready = !s1_valid_ff || s1_go;
   assign accept       = req_if.valid && req_if.ready;
   assign s1_valid_in  = req_if.ready ? accept : s1_valid_ff;
   assign burst_load   = s1_go && (list.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         held_ff     <= '0;
         iso_repl_ff <= a2hks_pkg::ISO_REPL_RESET;
         iso_key_ff  <= a2hks_pkg::ISO_KEY_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         iso_repl_ff <= iso_repl_in;
         iso_key_ff  <= iso_key_in;
         if (s1_go) begin
            held_ff <= held_next;
         end
      end
      if (accept) begin
         s1_mode_ff <= req_if.mode;
         s1_char_ff <= req_if.char_code;
      end
   end

   // write on load accept; read on every accept, data holds while the stage stalls
   a2hks_table_ram u_table (
      .clock   (clock),
      .wr_en   (accept && (req_if.mode == a2hks_pkg::MODE_LOAD)),
      .wr_addr (req_if.table_index),
      .wr_data (req_if.table_word),
      .rd_en   (accept),
      .rd_addr (req_if.char_code[a2hks_pkg::TABLE_AW-1:0]),
      .rd_data (entry)
   );

   a2hks_decode u_decode (
      .mode      (s1_mode_ff),
      .char_code (s1_char_ff),
      .entry     (entry),
      .iso_repl  (iso_repl_ff),
      .iso_key   (iso_key_ff),
      .held      (held_ff),
      .list      (list),
      .held_next (held_next)
   );

   a2hks_burst u_burst (
      .clock   (clock),
      .reset   (reset),
      .load_en (burst_load),
      .list    (list),
      .free    (burst_free),
      .rsp     (rsp_if)
   );
endmodule

[tb/tb_top.sv]
// Self-checking bench for ascii_to_hid_keystroke_sequencer: drives character words,
// predicts each key event in-line and checks every response word against that forecast.
// Depends on a2hks_pkg, the a2hks channel interfaces and the sequencer RTL.
module tb_top;

   // Spare register slots: writes there must leave both ISO registers alone.
   localparam logic [a2hks_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [a2hks_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // Characters with hand-picked layout entries (see load_entry).
   localparam logic [7:0] CHR_NO_CODE     = 8'h00;  // plain entry, code zero
   localparam logic [7:0] CHR_SHIFT_ZERO  = 8'h01;  // shift flag, code zero
   localparam logic [7:0] CHR_ALTGR_ZERO  = 8'h02;  // AltGr flag, code zero
   localparam logic [7:0] CHR_PLAIN_MAX   = 8'h03;  // largest plain code
   localparam logic [7:0] CHR_ISO_PLAIN   = 8'h04;  // code 50, no modifier
   localparam logic [7:0] CHR_ISO_SHIFT   = 8'h05;  // code 50 with shift
   localparam logic [7:0] CHR_ISO_ALTGR   = 8'h06;  // code 50 with AltGr
   localparam logic [7:0] CHR_AT          = 8'h40;  // AltGr key
   localparam logic [7:0] CHR_UPPER_A     = 8'h41;  // shifted key
   localparam logic [7:0] CHR_LOWER_A     = 8'h61;  // plain key
   localparam logic [7:0] CHR_DEL         = 8'h7F;  // entry 0xFF: AltGr, code 0x3F
   localparam logic [7:0] CHR_FIRST_HIGH  = 8'h80;
   localparam logic [7:0] CHR_LAST_HIGH   = 8'hFF;

   localparam int LOADED_LOW     = 32;    // entries 0 .. LOADED_LOW-1 load at start
   localparam int IDLE_PERCENT   = 35;
   localparam int DRAIN_CYCLES   = 12;    // covers pipeline plus a four-event burst
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on any channel

   typedef struct packed {
      logic [7:0] hid_code;
      logic       pressed;
      logic       is_translation;
      logic       last_of_run;
   } keystroke_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   a2hks_req_if req_if();
   a2hks_rsp_if rsp_if();
   a2hks_csr_if csr_if();

   ascii_to_hid_keystroke_sequencer DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the block state, updated at every accepted word and register write.
   logic [7:0] layout_mirror [a2hks_pkg::TABLE_DEPTH];
   bit         layout_loaded [a2hks_pkg::TABLE_DEPTH];
   logic       shift_mirror   = 1'b0;
   logic       altgr_mirror   = 1'b0;
   logic [7:0] iso_repl_mirror = a2hks_pkg::ISO_REPL_RESET;
   logic [7:0] iso_key_mirror  = a2hks_pkg::ISO_KEY_RESET;

   keystroke_type keystrokes_due[$];   // forecast response words, oldest first
   int            mismatch_count = 0;
   bit            steady = 1'b0;       // set: neither side inserts idle cycles

   // ------------------------------------------------------------------------
   // Keystroke forecast
   // ------------------------------------------------------------------------

   // Resolve a character to its key code and needed modifiers. Characters at
   // 128 and above never touch the table and resolve to code zero.
   function automatic void decode_layout(input logic [7:0] ch, output logic [7:0] code,
                                         output logic need_shift, output logic need_altgr);
      logic [7:0] entry;
      need_shift = 1'b0;
      need_altgr = 1'b0;
      code       = 8'h00;
      if (!ch[7]) begin
         entry = layout_mirror[ch[6:0]];
         if (entry[7:6] == 2'b11) begin
            need_altgr = 1'b1;
            entry      = entry & 8'h3f;
         end else if (entry[7]) begin
            need_shift = 1'b1;
            entry      = entry & 8'h7f;
         end
         code = (entry == iso_repl_mirror) ? iso_key_mirror : entry;
      end
   endfunction

   function automatic void queue_keystroke(input logic [7:0] hid, input logic pressed,
                                           input logic trans);
      keystroke_type ks;
      ks.hid_code       = hid;
      ks.pressed        = pressed;
      ks.is_translation = trans;
      ks.last_of_run    = 1'b0;
      keystrokes_due.push_back(ks);
   endfunction

   // Advance the shadow state by one accepted word and queue the events it causes.
   function automatic void predict_keystrokes(input logic [1:0] mode, input logic [6:0] idx,
                                              input logic [7:0] word, input logic [7:0] ch);
      logic [7:0] code;
      logic       need_shift;
      logic       need_altgr;
      int         queued_before;
      queued_before = keystrokes_due.size();
      case (mode)
         a2hks_pkg::MODE_LOAD: begin
            layout_mirror[idx] = word;
            layout_loaded[idx] = 1'b1;
         end
         a2hks_pkg::MODE_TYPE: begin
            decode_layout(ch, code, need_shift, need_altgr);
            if (code != 8'h00) begin
               if (need_shift != shift_mirror) begin
                  shift_mirror = need_shift;
                  queue_keystroke(a2hks_pkg::HID_LSHIFT, need_shift, 1'b0);
               end
               if (need_altgr != altgr_mirror) begin
                  altgr_mirror = need_altgr;
                  queue_keystroke(a2hks_pkg::HID_RALT, need_altgr, 1'b0);
               end
               queue_keystroke(code, 1'b1, 1'b0);
               queue_keystroke(code, 1'b0, 1'b0);
            end
         end
         a2hks_pkg::MODE_TRANSLATE: begin
            if (ch >= 8'h10 && ch <= 8'h17) begin
               code = a2hks_pkg::HID_MOD_BASE + {5'd0, ch[2:0]};
            end else if (ch > 8'h80) begin
               code = ch - 8'h80;
            end else begin
               decode_layout(ch, code, need_shift, need_altgr);
            end
            queue_keystroke(code, 1'b0, 1'b1);
         end
         default: begin
            if (shift_mirror) queue_keystroke(a2hks_pkg::HID_LSHIFT, 1'b0, 1'b0);
            if (altgr_mirror) queue_keystroke(a2hks_pkg::HID_RALT, 1'b0, 1'b0);
            shift_mirror = 1'b0;
            altgr_mirror = 1'b0;
         end
      endcase
      if (keystrokes_due.size() > queued_before)
         keystrokes_due[keystrokes_due.size() - 1].last_of_run = 1'b1;
   endfunction

   // Random character below 128 whose table entry has been written.
   function automatic logic [7:0] pick_loaded_char();
      logic [6:0] pick;
      pick = 7'($urandom_range(127));
      while (!layout_loaded[pick]) pick = 7'($urandom_range(127));
      return {1'b0, pick};
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Present one word, idling at random first; leave valid high after the
   // handshake so back-to-back words need no extra edge.
   task automatic send_word(input logic [1:0] mode, input logic [6:0] idx,
                            input logic [7:0] word, input logic [7:0] ch);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid       <= 1'b0;
         req_if.mode        <= 2'($urandom);
         req_if.table_index <= 7'($urandom);
         req_if.table_word  <= 8'($urandom);
         req_if.char_code   <= 8'($urandom);
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.mode        <= mode;
      req_if.table_index <= idx;
      req_if.table_word  <= word;
      req_if.char_code   <= ch;
      do @(posedge clock); while (!req_if.ready);
      predict_keystrokes(mode, idx, word, ch);
   endtask

   // Non-load word: fill the unused load fields with noise.
   task automatic send_op(input logic [1:0] mode, input logic [7:0] ch);
      send_word(mode, 7'($urandom), 8'($urandom), ch);
   endtask

   // Drop valid, wait for every forecast event, then give the block time to
   // finish any word that produces nothing.
   task automatic drain_and_hold();
      req_if.valid <= 1'b0;
      while (keystrokes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [a2hks_pkg::CSR_IDX_W-1:0] index,
                                 input logic [7:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      case (index)
         a2hks_pkg::CSR_ISO_REPL: iso_repl_mirror = data;
         a2hks_pkg::CSR_ISO_KEY:  iso_key_mirror  = data;
         default: ;
      endcase
   endtask

   // Reprogram both ISO registers with a spare-slot write between them.
   task automatic configure_iso(input logic [7:0] repl, input logic [7:0] key);
      drain_and_hold();
      write_register(a2hks_pkg::CSR_ISO_REPL, repl);
      write_register($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, 8'($urandom));
      write_register(a2hks_pkg::CSR_ISO_KEY, key);
      csr_if.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Load one layout entry, hand-picked for the named characters.
   task automatic load_entry(input logic [7:0] ch);
      logic [7:0] entry;
      case (ch)
         CHR_NO_CODE:    entry = 8'h00;
         CHR_SHIFT_ZERO: entry = 8'h80;
         CHR_ALTGR_ZERO: entry = 8'hC0;
         CHR_PLAIN_MAX:  entry = 8'h7F;
         CHR_ISO_PLAIN:  entry = 8'd50;
         CHR_ISO_SHIFT:  entry = 8'h80 | 8'd50;
         CHR_ISO_ALTGR:  entry = 8'hC0 | 8'd50;
         CHR_AT:         entry = 8'hD4;
         CHR_UPPER_A:    entry = 8'h84;
         CHR_LOWER_A:    entry = 8'h04;
         CHR_DEL:        entry = 8'hFF;
         default:        entry = 8'($urandom);
      endcase
      send_word(a2hks_pkg::MODE_LOAD, ch[6:0], entry, 8'($urandom));
   endtask

   // Write the low block and the named characters; later lookups only ever
   // hit entries that have been written.
   task automatic load_layout();
      for (int i = 0; i < LOADED_LOW; i++) begin
         load_entry(8'(i));
      end
      load_entry(CHR_AT);
      load_entry(CHR_UPPER_A);
      load_entry(CHR_LOWER_A);
      load_entry(CHR_DEL);
   endtask

   // Walk the modifier state through press/release changes of shift and AltGr.
   task automatic test_modifiers();
      send_op(a2hks_pkg::MODE_TYPE, CHR_LOWER_A);     // key only
      send_op(a2hks_pkg::MODE_TYPE, CHR_UPPER_A);     // shift press
      send_op(a2hks_pkg::MODE_TYPE, CHR_AT);          // shift release, AltGr press
      send_op(a2hks_pkg::MODE_TYPE, CHR_UPPER_A);     // shift press, AltGr release
      send_op(a2hks_pkg::MODE_TYPE, CHR_AT);
      send_op(a2hks_pkg::MODE_FINISH, 8'($urandom)); // AltGr release
      send_op(a2hks_pkg::MODE_FINISH, 8'($urandom)); // nothing held, nothing sent
      send_op(a2hks_pkg::MODE_TYPE, CHR_DEL);
      send_op(a2hks_pkg::MODE_TYPE, CHR_UPPER_A);
      send_op(a2hks_pkg::MODE_FINISH, 8'($urandom)); // shift release
   endtask

   // Skipped characters must leave the held modifiers where they were.
   task automatic test_skipped_characters();
      send_op(a2hks_pkg::MODE_TYPE, CHR_UPPER_A);
      send_op(a2hks_pkg::MODE_TYPE, CHR_NO_CODE);
      send_op(a2hks_pkg::MODE_TYPE, CHR_SHIFT_ZERO);
      send_op(a2hks_pkg::MODE_TYPE, CHR_ALTGR_ZERO);
      send_op(a2hks_pkg::MODE_TYPE, CHR_FIRST_HIGH);
      send_op(a2hks_pkg::MODE_TYPE, CHR_LAST_HIGH);
      send_op(a2hks_pkg::MODE_TYPE, CHR_PLAIN_MAX);   // shift release expected here
   endtask

   // Every translate range and its edges, with AltGr held across them.
   task automatic test_translation();
      send_op(a2hks_pkg::MODE_TYPE, CHR_AT);
      send_op(a2hks_pkg::MODE_TRANSLATE, 8'h0F);
      send_op(a2hks_pkg::MODE_TRANSLATE, 8'h10);
      send_op(a2hks_pkg::MODE_TRANSLATE, 8'h17);
      send_op(a2hks_pkg::MODE_TRANSLATE, 8'h18);
      send_op(a2hks_pkg::MODE_TRANSLATE, CHR_FIRST_HIGH);
      send_op(a2hks_pkg::MODE_TRANSLATE, 8'h81);
      send_op(a2hks_pkg::MODE_TRANSLATE, CHR_LAST_HIGH);
      send_op(a2hks_pkg::MODE_TRANSLATE, CHR_UPPER_A);
      send_op(a2hks_pkg::MODE_TRANSLATE, CHR_NO_CODE);
      send_op(a2hks_pkg::MODE_TRANSLATE, CHR_DEL);
      send_op(a2hks_pkg::MODE_FINISH, 8'($urandom));
   endtask

   // Characters whose outcome hinges on the ISO registers.
   task automatic probe_iso_entries();
      send_op(a2hks_pkg::MODE_TYPE, CHR_NO_CODE);
      send_op(a2hks_pkg::MODE_TYPE, CHR_SHIFT_ZERO);
      send_op(a2hks_pkg::MODE_TYPE, CHR_ALTGR_ZERO);
      send_op(a2hks_pkg::MODE_TYPE, CHR_ISO_PLAIN);
      send_op(a2hks_pkg::MODE_TYPE, CHR_ISO_SHIFT);
      send_op(a2hks_pkg::MODE_TYPE, CHR_ISO_ALTGR);
      send_op(a2hks_pkg::MODE_TRANSLATE, CHR_ISO_PLAIN);
      send_op(a2hks_pkg::MODE_FINISH, 8'($urandom));
   endtask

   // Mostly typed characters, some translations and finishes, and a few table
   // rewrites; only words that can produce events count toward the total.
   task automatic random_mix(input int count);
      int         counted;
      int         pick;
      logic [7:0] ch;
      counted = 0;
      while (counted < count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            if ($urandom_range(9) == 0) ch = 8'($urandom_range(255, 128));
            else                        ch = pick_loaded_char();
            send_op(a2hks_pkg::MODE_TYPE, ch);
            counted++;
         end else if (pick < 72) begin
            case ($urandom_range(3))
               0:       ch = 8'h10 + 8'($urandom_range(7));
               1:       ch = 8'($urandom_range(255, 128));
               default: ch = pick_loaded_char();
            endcase
            send_op(a2hks_pkg::MODE_TRANSLATE, ch);
            counted++;
         end else if (pick < 85) begin
            send_op(a2hks_pkg::MODE_FINISH, 8'($urandom));
            counted++;
         end else begin
            send_word(a2hks_pkg::MODE_LOAD, 7'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   // Run traffic under several register settings, the extremes among them.
   task automatic test_iso_registers();
      probe_iso_entries();                 // reset values
      random_mix(8);
      configure_iso(8'h00, 8'hFF);         // code zero now maps to 0xFF
      probe_iso_entries();
      random_mix(8);
      configure_iso(8'hFF, 8'h00);         // replacement can never match
      probe_iso_entries();
      random_mix(8);
      steady = 1'b1;                       // back-to-back stretch on both sides
      configure_iso(8'($urandom_range(1, 63)), 8'h00);
      probe_iso_entries();
      random_mix(16);
      steady = 1'b0;
      configure_iso(8'h7F, 8'hFF);
      probe_iso_entries();
      random_mix(8);
      configure_iso(8'($urandom_range(1, 63)), 8'($urandom));
      probe_iso_entries();
      random_mix(8);
   endtask

   // ------------------------------------------------------------------------
   // Response checker: compare each accepted word with the oldest forecast,
   // then pick next cycle's ready.
   // ------------------------------------------------------------------------

   function automatic void compare_field(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   initial begin : response_checker
      keystroke_type want;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (keystrokes_due.size() == 0) begin
               $display("%0t: unexpected word, expected none got hid_code %h pressed %b",
                        $time, rsp_if.hid_code, rsp_if.pressed);
               mismatch_count++;
            end else begin
               want = keystrokes_due.pop_front();
               compare_field("hid_code", want.hid_code, rsp_if.hid_code);
               compare_field("pressed", {7'd0, want.pressed}, {7'd0, rsp_if.pressed});
               compare_field("is_translation", {7'd0, want.is_translation},
                             {7'd0, rsp_if.is_translation});
               compare_field("last_of_run", {7'd0, want.last_of_run},
                             {7'd0, rsp_if.last_of_run});
            end
         end
         rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: a run with no handshake on any channel for too long is hung.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("ascii_to_hid_keystroke_sequencer: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : test_sequence
      // Drive every input to a known value before reset releases.
      req_if.valid       <= 1'b0;
      req_if.mode        <= a2hks_pkg::MODE_LOAD;
      req_if.table_index <= '0;
      req_if.table_word  <= '0;
      req_if.char_code   <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= a2hks_pkg::CSR_ISO_REPL;
      csr_if.data        <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      load_layout();
      test_modifiers();
      test_skipped_characters();
      test_translation();
      test_iso_registers();

      // Hold until every forecast event has arrived, then a short tail for strays.
      drain_and_hold();
      if (mismatch_count == 0) begin
         $display("ascii_to_hid_keystroke_sequencer: match");
      end else begin
         $display("ascii_to_hid_keystroke_sequencer: mismatch");
      end
      $finish;
   end

endmodule
